// ===== rtl/abff_pkg.sv =====
// shared types and constants of the allocation bitmap
// request and response structs, command codes, default sizes
package abff_pkg;

	localparam int MAX_WORDS_DEF = 64;
	localparam int WORD_BITS_DEF = 64;

	localparam int CMD_W = 2;
	localparam int IDX_W = 12;
	localparam int CFG_W = 7;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FIND  = 2'd2;

	localparam logic [CFG_W-1:0] ACTIVE_WORDS_RST = 7'd64;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             bit_value;
		logic [IDX_W-1:0] bit_pos;
	} abff_req_t;

	typedef struct packed {
		logic             read_bit;
		logic [IDX_W-1:0] free_index;
		logic             free_found;
		logic             index_error;
	} abff_rsp_t;

endpackage

// ===== rtl/allocation_bitmap_first_free.sv =====
// Allocation bitmap with a find-first-zero search. The bitmap lives in one ram of
// MAX_WORDS words of WORD_BITS bits; bit n is bit n mod WORD_BITS of word n / WORD_BITS.
// Three requests: write one bit, read one bit, and find the lowest zero bit among
// the first active_words words (values above MAX_WORDS act as MAX_WORDS). A find does
// not mark the bit it returns; when every word in use is full it reports not found
// with free_index 0. A write or read whose word lies beyond the words in use raises
// index_error, a write then changes nothing and a read returns 0. Command code 3
// does nothing and returns all zero. Every request gives exactly one response.
// Timing: the block handles one request at a time. A write or read goes from acceptance
// to response through word index, ram read, and modify and write back; one whose
// word lies beyond the words in use, and command code 3, skip the ram read and the
// modify step as the ram is not used. A find reads one word per cycle through the
// single ram read port until it finds a free bit or every word in use is examined;
// with no words in use it reads none. A new request is accepted in the cycle after
// the response is registered, even if the response still waits for the far side;
// its own response then waits until the held one is taken.
// After reset the bitmap reads as all zero at once: one valid flip-flop per word
// stands in for the ram content, so there is no clearing pass. The user writes
// active_words only while the block is idle; the block itself does not enforce it.
// depends on abff_pkg and abff_ram
module allocation_bitmap_first_free #(
	parameter int MAX_WORDS = abff_pkg::MAX_WORDS_DEF,
	parameter int WORD_BITS = abff_pkg::WORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  abff_pkg::abff_req_t          in_req,
	output logic                         out_valid,
	input  logic                         out_stall,
	output abff_pkg::abff_rsp_t          out_rsp,
	input  logic                         cfg_we,
	input  logic [abff_pkg::CFG_W-1:0]   cfg_data
);

	import abff_pkg::*;

	// ram address, word offset and word number widths
	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int OW = $clog2(WORD_BITS);
	localparam int QW = $clog2((4095 / WORD_BITS) + 1);
	localparam int UW = $clog2(MAX_WORDS + 1);
	// common width for word compares: holds a word number, the used count and an address
	localparam int CW0 = (UW > CFG_W) ? UW : CFG_W;
	localparam int CW1 = (CW0 > QW) ? CW0 : QW;
	localparam int CW  = (CW1 > AW) ? CW1 : AW;

	// word number by reciprocal multiply: exact for 12-bit indexes since
	// 4096 * WORD_BITS stays below 2**SH
	localparam int SH    = 19;
	localparam int RECIP = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
	localparam int RW    = $clog2(RECIP + 1);
	localparam int PW    = IDX_W + RW;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DIV  = 5'b00010,
		S_ADDR = 5'b00100,
		S_MOD  = 5'b01000,
		S_FIND = 5'b10000
	} state_t;

	// lowest zero position of a word, caller guarantees one exists
	function automatic logic [OW-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
		logic [OW-1:0] pos;
		pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				pos = OW'(i);
			end
		end
		return pos;
	endfunction

	state_t             state_q;
	abff_req_t          req_q;
	logic [CFG_W-1:0]   active_words_q;
	logic [QW-1:0]      word_q;
	logic [OW-1:0]      off_q;
	logic [CW-1:0]      scan_q;
	logic [IDX_W-1:0]   base_q;
	logic [IDX_W-1:0]   base_s1;
	logic               pend_s1;
	logic               vld_s1;
	logic [MAX_WORDS-1:0] word_vld_q;
	logic               out_vld_q;
	abff_rsp_t          rsp_q;

	// combinational helpers
	logic [CW-1:0]      used_c;
	logic [CW-1:0]      word_ext;
	logic [PW-1:0]      prod_c;
	logic [IDX_W-1:0]   word_base_c;
	logic               rw_cmd;
	logic               in_range;
	logic               out_free;
	logic               accept;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic               ram_we;
	logic [WORD_BITS-1:0] ram_rdata;
	logic [WORD_BITS-1:0] word_eff;
	logic [WORD_BITS-1:0] bit_mask;
	logic [WORD_BITS-1:0] wdata_c;
	logic               scan_more;
	logic               hit;
	logic               miss_all;
	logic               finish;
	abff_rsp_t          rsp_c;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_vld_q || !out_stall;

	// words in use, clamped to the ram depth
	assign used_c = (CW'(active_words_q) > CW'(MAX_WORDS)) ? CW'(MAX_WORDS)
	                                                       : CW'(active_words_q);

	// word number and offset of the addressed bit
	assign prod_c      = PW'(req_q.bit_pos) * PW'(RECIP);
	assign word_ext    = CW'(word_q);
	assign word_base_c = IDX_W'(word_q * WORD_BITS);
	assign rw_cmd      = (req_q.cmd == CMD_WRITE) || (req_q.cmd == CMD_READ);
	assign in_range    = word_ext < used_c;

	// a word never written reads as zero
	assign word_eff = vld_s1 ? ram_rdata : '0;
	assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << off_q;
	assign wdata_c  = req_q.bit_value ? (word_eff | bit_mask) : (word_eff & ~bit_mask);

	// scan control
	assign scan_more = scan_q < used_c;
	assign hit       = pend_s1 && (word_eff != '1);
	assign miss_all  = !pend_s1 && !scan_more;

	// ram access selection
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = word_ext[AW-1:0];
		if (state_q == S_ADDR) begin
			ram_re = rw_cmd && in_range;
		end else if (state_q == S_FIND) begin
			ram_re    = scan_more && !hit && !miss_all;
			ram_raddr = scan_q[AW-1:0];
		end
	end

	assign ram_we = (state_q == S_MOD) && out_free && (req_q.cmd == CMD_WRITE);

	// response build and finish condition
	always_comb begin
		rsp_c  = '0;
		finish = 1'b0;
		unique case (state_q)
			S_ADDR: begin
				if (!(rw_cmd && in_range)) begin
					rsp_c.index_error = rw_cmd;
					finish            = out_free;
				end
			end
			S_MOD: begin
				if (req_q.cmd == CMD_READ) begin
					rsp_c.read_bit = word_eff[off_q];
				end
				finish = out_free;
			end
			S_FIND: begin
				if (hit) begin
					rsp_c.free_found = 1'b1;
					rsp_c.free_index = base_s1 + IDX_W'(lowest_zero(word_eff));
				end
				finish = (hit || miss_all) && out_free;
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end

	abff_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAX_WORDS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (word_ext[AW-1:0]),
		.wdata (wdata_c),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			active_words_q <= ACTIVE_WORDS_RST;
			word_vld_q     <= '0;
			out_vld_q      <= 1'b0;
			pend_s1        <= 1'b0;
		end else begin
			if (cfg_we) begin
				active_words_q <= cfg_data;
			end
			if (ram_we) begin
				word_vld_q[word_ext[AW-1:0]] <= 1'b1;
			end
			if (finish) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (accept) begin
						if (in_req.cmd == CMD_FIND) begin
							state_q <= S_FIND;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					state_q <= S_ADDR;
				end
				S_ADDR: begin
					if (ram_re) begin
						state_q <= S_MOD;
					end else if (finish) begin
						state_q <= S_IDLE;
					end
				end
				S_MOD: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				S_FIND: begin
					if (finish) begin
						state_q <= S_IDLE;
					end else if (!hit && !miss_all) begin
						pend_s1 <= ram_re;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= in_req;
			scan_q <= '0;
			base_q <= '0;
		end
		if (state_q == S_DIV) begin
			word_q <= prod_c[SH +: QW];
		end
		if (state_q == S_ADDR) begin
			off_q <= OW'(req_q.bit_pos - word_base_c);
		end
		if (ram_re) begin
			vld_s1 <= word_vld_q[ram_raddr];
		end
		if ((state_q == S_FIND) && ram_re) begin
			scan_q  <= scan_q + CW'(1);
			base_s1 <= base_q;
			base_q  <= base_q + IDX_W'(WORD_BITS);
		end
		if (finish) begin
			rsp_q <= rsp_c;
		end
	end

	assign out_valid = out_vld_q;
	assign out_rsp   = rsp_q;

endmodule

// ===== rtl/abff_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module abff_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/abff_chk.sv =====
// port-level checks of the allocation bitmap, bound to the top level
// depends on abff_pkg and allocation_bitmap_first_free
module abff_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input abff_pkg::abff_rsp_t out_rsp
);

	import abff_pkg::*;

	// a held response keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_rsp))
		else $error("held response changed");

	// one request at a time: acceptance closes the input
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while one is in flight");

	// an index error response carries nothing else
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_rsp.index_error |->
			!out_rsp.read_bit && !out_rsp.free_found && (out_rsp.free_index == '0))
		else $error("index error response with other fields set");

	// free_index is zero unless a free bit was found
	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_rsp.free_found |-> (out_rsp.free_index == '0))
		else $error("free index without found flag");

endmodule

bind allocation_bitmap_first_free abff_chk u_abff_chk (.*);
